// ----- rtl/kre_pkg.sv -----
// ----------------------------------------------------------------------------
// kre_pkg
// Types and constants shared by the kinetics record extractor modules.
// ----------------------------------------------------------------------------
package kre_pkg;

  // One input word: a file byte and the end-of-file flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } kre_in_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        field_last;
    logic        record_last;
  } kre_out_t;

  // Control from the parser to the marker window.
  typedef struct packed {
    logic shift;
    logic clear;
  } kre_win_ctrl_t;

  // Result kinds.
  localparam logic [2:0] KIND_RECORD_START = 3'd0;
  localparam logic [2:0] KIND_ABSORBANCE   = 3'd1;
  localparam logic [2:0] KIND_TIME         = 3'd2;
  localparam logic [2:0] KIND_FIELD_LEN    = 3'd3;
  localparam logic [2:0] KIND_FIELD_BYTE   = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TO_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TO_POINTS = 2'd1;

  // Configuration reset values.
  localparam logic [15:0] GAP_TO_COUNT_RST    = 16'h001C;
  localparam logic [15:0] COUNT_TO_POINTS_RST = 16'h03EC;

  // Bytes in a little-endian data word; also the least count-to-points distance.
  localparam logic [15:0] WORD_BYTES = 16'd4;

  // Record marker text "TContinuumStore", zero padded to 16 bytes.
  localparam logic [7:0] MARKER_TEXT [16] = '{
    8'h54, 8'h43, 8'h6F, 8'h6E, 8'h74, 8'h69, 8'h6E, 8'h75,
    8'h75, 8'h6D, 8'h53, 8'h74, 8'h6F, 8'h72, 8'h65, 8'h00
  };

  // Closing field text "End Method", zero padded to 16 bytes.
  localparam logic [7:0] END_TEXT [16] = '{
    8'h45, 8'h6E, 8'h64, 8'h20, 8'h4D, 8'h65, 8'h74, 8'h68,
    8'h6F, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

// ----- rtl/kre_marker_window.sv -----
// ----------------------------------------------------------------------------
// kre_marker_window
// Sliding window over the most recent bytes with a compare against the
// record marker. Reports a hit for the byte being shifted in.
// ----------------------------------------------------------------------------
module kre_marker_window #(
  parameter int unsigned MARKER_LEN = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kre_pkg::kre_win_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  output logic                 hit_o
);
  import kre_pkg::*;

  localparam int unsigned FILL_W = $clog2(MARKER_LEN + 1);

  logic [7:0]        window_q [MARKER_LEN];
  logic [7:0]        window_d [MARKER_LEN];
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;
  logic              text_match;

  // Shift the new byte in at the top and compare the whole window.
  always_comb begin
    for (int i = 0; i < int'(MARKER_LEN) - 1; i++) begin
      window_d[i] = window_q[i+1];
    end
    window_d[MARKER_LEN-1] = byte_i;
    text_match = 1'b1;
    for (int i = 0; i < int'(MARKER_LEN); i++) begin
      if (window_d[i] != MARKER_TEXT[i]) begin
        text_match = 1'b0;
      end
    end
    if (fill_q < FILL_W'(MARKER_LEN)) begin
      fill_d = fill_q + FILL_W'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  // A hit needs a full window of bytes received since the search began.
  assign hit_o = text_match && (fill_d == FILL_W'(MARKER_LEN));

  // Window bytes only count once the fill reaches the marker length, so the
  // bytes themselves need no reset or clear.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.clear) begin
      fill_q <= '0;
    end else if (ctrl_i.shift) begin
      fill_q <= fill_d;
    end
  end

endmodule

// ----- rtl/kre_parser.sv -----
// ----------------------------------------------------------------------------
// kre_parser
// Record parser: phase sequencer, skip and point counters, word assembly,
// field parsing with the closing-field test, and the configuration registers.
// ----------------------------------------------------------------------------
module kre_parser #(
  parameter int unsigned END_LEN = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [kre_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             accept_i,
  input  kre_pkg::kre_in_t                 in_data_i,
  input  logic                             marker_hit_i,
  output kre_pkg::kre_win_ctrl_t           win_ctrl_o,
  output logic                             res_valid_o,
  output kre_pkg::kre_out_t                res_o,
  output logic                             searching_o
);
  import kre_pkg::*;

  localparam int unsigned END_W = $clog2(END_LEN + 1);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_GAP,
    PH_COUNT,
    PH_PRESKIP,
    PH_POINTS,
    PH_FLEN,
    PH_FBYTES
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [15:0]      gap_q, gap_d;
  logic [15:0]      ctp_q, ctp_d;
  logic [15:0]      skip_q, skip_d;
  logic [23:0]      asm_q, asm_d;
  logic [1:0]       bidx_q, bidx_d;
  logic [31:0]      points_q, points_d;
  logic             time_half_q, time_half_d;
  logic [31:0]      field_q, field_d;
  logic [END_W-1:0] end_idx_q, end_idx_d;
  logic             end_ok_q, end_ok_d;

  logic [7:0]       b;
  logic             word_phase;
  logic             word_done;
  logic [31:0]      word;
  logic [15:0]      skip_dec;
  logic [15:0]      ctp_eff;
  logic [31:0]      points_dec;
  logic [31:0]      field_dec;
  logic [4:0]       end_idx_ext;
  logic             go_search;

  assign b = in_data_i.data_byte;

  // Configuration writes; an unknown index is ignored.
  always_comb begin
    gap_d = gap_q;
    ctp_d = ctp_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAP_TO_COUNT:    gap_d = cfg_data_i;
        CFG_COUNT_TO_POINTS: ctp_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared helpers for counters and the little-endian word assembly.
  always_comb begin
    word_phase = (phase_q == PH_COUNT) || (phase_q == PH_POINTS) ||
                 (phase_q == PH_FLEN);
    word_done  = (bidx_q == 2'd3);
    word       = {b, asm_q};
    skip_dec   = (skip_q != 16'd0) ? (skip_q - 16'd1) : skip_q;
    points_dec = (points_q != 32'd0) ? (points_q - 32'd1) : points_q;
    field_dec  = (field_q != 32'd0) ? (field_q - 32'd1) : field_q;
    ctp_eff    = (ctp_q < WORD_BYTES) ? WORD_BYTES : ctp_q;
    end_idx_ext = 5'(end_idx_q);
  end

  // Next state and result for the accepted byte.
  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    asm_d       = asm_q;
    bidx_d      = bidx_q;
    points_d    = points_q;
    time_half_d = time_half_q;
    field_d     = field_q;
    end_idx_d   = end_idx_q;
    end_ok_d    = end_ok_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    go_search   = 1'b0;

    if (accept_i) begin
      // Word assembly runs in every phase that reads 32-bit words.
      if (word_phase) begin
        if (word_done) begin
          asm_d  = '0;
          bidx_d = '0;
        end else begin
          asm_d  = asm_q | (24'(b) << {bidx_q, 3'b000});
          bidx_d = bidx_q + 2'd1;
        end
      end

      case (phase_q)
        PH_SEARCH: begin
          if (marker_hit_i) begin
            go_search = 1'b1;
          end
        end
        PH_GAP: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (word_done) begin
            points_d       = word;
            time_half_d    = 1'b0;
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_RECORD_START;
            res_o.value    = word;
            skip_d         = ctp_eff - WORD_BYTES;
            if (skip_d != 16'd0) begin
              phase_d = PH_PRESKIP;
            end else if (word != 32'd0) begin
              phase_d = PH_POINTS;
            end else begin
              phase_d = PH_FLEN;
            end
          end
        end
        PH_PRESKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = (points_q != 32'd0) ? PH_POINTS : PH_FLEN;
          end
        end
        PH_POINTS: begin
          if (word_done) begin
            res_valid_o = 1'b1;
            res_o.value = word;
            if (!time_half_q) begin
              res_o.kind  = KIND_ABSORBANCE;
              time_half_d = 1'b1;
            end else begin
              res_o.kind  = KIND_TIME;
              time_half_d = 1'b0;
              points_d    = points_dec;
              if (points_dec == 32'd0) begin
                phase_d = PH_FLEN;
              end
            end
          end
        end
        PH_FLEN: begin
          if (word_done) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_FIELD_LEN;
            res_o.value = word;
            field_d     = word;
            end_idx_d   = '0;
            end_ok_d    = 1'b1;
            if (word == 32'd0) begin
              res_o.field_last = 1'b1;
            end else begin
              phase_d = PH_FBYTES;
            end
          end
        end
        PH_FBYTES: begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_FIELD_BYTE;
          res_o.value = 32'(b);
          // Compare the leading bytes of the field against the closing text.
          if (end_idx_q < END_W'(END_LEN)) begin
            if (b != END_TEXT[end_idx_ext[3:0]]) begin
              end_ok_d = 1'b0;
            end
            end_idx_d = end_idx_q + END_W'(1);
          end
          field_d = field_dec;
          if (field_dec == 32'd0) begin
            res_o.field_last = 1'b1;
            if (end_ok_d && (end_idx_d == END_W'(END_LEN))) begin
              res_o.record_last = 1'b1;
              go_search         = 1'b1;
            end else begin
              phase_d = PH_FLEN;
            end
          end
        end
        default: begin
          go_search = 1'b1;
        end
      endcase

      if (in_data_i.last_byte) begin
        go_search = 1'b1;
      end
    end

    // Return to the search; a marker hit then moves on to the gap or count.
    if (go_search) begin
      phase_d     = PH_SEARCH;
      skip_d      = '0;
      asm_d       = '0;
      bidx_d      = '0;
      time_half_d = 1'b0;
      if (phase_q == PH_SEARCH && marker_hit_i && !in_data_i.last_byte) begin
        skip_d  = gap_q;
        phase_d = (gap_q != 16'd0) ? PH_GAP : PH_COUNT;
      end
    end
  end

  // Window control: shift while searching, clear whenever a search restarts.
  assign win_ctrl_o.shift = accept_i && (phase_q == PH_SEARCH);
  assign win_ctrl_o.clear = go_search;
  assign searching_o      = (phase_q == PH_SEARCH);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCH;
      gap_q       <= GAP_TO_COUNT_RST;
      ctp_q       <= COUNT_TO_POINTS_RST;
      skip_q      <= '0;
      asm_q       <= '0;
      bidx_q      <= '0;
      points_q    <= '0;
      time_half_q <= 1'b0;
      field_q     <= '0;
      end_idx_q   <= '0;
      end_ok_q    <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      gap_q       <= gap_d;
      ctp_q       <= ctp_d;
      skip_q      <= skip_d;
      asm_q       <= asm_d;
      bidx_q      <= bidx_d;
      points_q    <= points_d;
      time_half_q <= time_half_d;
      field_q     <= field_d;
      end_idx_q   <= end_idx_d;
      end_ok_q    <= end_ok_d;
    end
  end

endmodule

// ----- rtl/kre_out_reg.sv -----
// ----------------------------------------------------------------------------
// kre_out_reg
// Result register between the parser and the output channel. Takes a new
// word in the same cycle the held one is taken.
// ----------------------------------------------------------------------------
module kre_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kre_pkg::kre_out_t data_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kre_pkg::kre_out_t out_data_o
);
  import kre_pkg::*;

  logic     valid_q;
  kre_out_t data_q;

  // Room for a new word when empty or when the held word leaves this cycle.
  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- rtl/kinetics_record_extractor_core.sv -----
// ----------------------------------------------------------------------------
// kinetics_record_extractor_core
// Extracts kinetics records from a file byte stream: record start with point
// count, raw absorbance and time words, then length-prefixed fields.
//
// Input channel: one file byte per word with a last-byte flag. Output
// channel: one result word (kind, value, field_last, record_last). Most
// bytes produce no result. Configuration channel: register index and 16-bit
// data, always ready; write only while the block is idle.
// Throughput is one byte per cycle unless the output stalls. A result is
// held in the result register, on the output, in the cycle after acceptance.
// Input ready stays high while the result register is empty or being taken,
// so when the receiver stalls with a result waiting, input stalls too.
// Reset returns the parser to the marker search with the default gap (28)
// and count-to-points distance (1004); no clearing pass is needed.
// ----------------------------------------------------------------------------
module kinetics_record_extractor_core #(
  parameter int unsigned MARKER_LEN = 15,
  parameter int unsigned END_LEN    = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kre_pkg::kre_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kre_pkg::kre_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import kre_pkg::*;

  logic          accept;
  logic          marker_hit;
  kre_win_ctrl_t win_ctrl;
  logic          res_valid;
  kre_out_t      res;
  logic          searching;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Marker search window.
  kre_marker_window #(
    .MARKER_LEN (MARKER_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .byte_i (in_data_i.data_byte),
    .hit_o  (marker_hit)
  );

  // Record parser.
  kre_parser #(
    .END_LEN (END_LEN)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .in_data_i    (in_data_i),
    .marker_hit_i (marker_hit),
    .win_ctrl_o   (win_ctrl),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .searching_o  (searching)
  );

  // Result register.
  kre_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && res_valid),
    .data_i      (res),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

  // The last byte of the file always sends the parser back to the search.
  a_last_byte_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.last_byte) |=> searching)
    else $error("parser not searching after the last byte");

  // A record closes only on the final byte of a field.
  a_record_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.record_last) |->
      (out_data_o.field_last && out_data_o.kind == KIND_FIELD_BYTE))
    else $error("record_last on a word that is not a closing field byte");
`endif

endmodule

// ----- test/kinetics_record_extractor_core_tb.sv -----
// ----------------------------------------------------------------------------
// kinetics_record_extractor_core_tb
// Self-checking testbench for the kinetics record extractor. It streams file
// bytes into the block, predicts every result word with its own parser model
// and compares each result field by field. Directed records cover the reset
// settings, short and zero skip distances, zero points, the closing field
// test and truncated records. The random phases mix well-formed records with
// noise and broken records; in all but the last, both sides stall at random.
// ----------------------------------------------------------------------------
module kinetics_record_extractor_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import kre_pkg::*;

  // Parser phases of the prediction model.
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_GAP,
    PH_COUNT,
    PH_PRESKIP,
    PH_POINTS,
    PH_FLEN,
    PH_FBYTES
  } parse_phase_e;

  localparam int unsigned MARKER_LEN   = 15;
  localparam int unsigned END_LEN      = 10;
  localparam string       MARKER_S     = "TContinuumStore";
  localparam string       END_S        = "End Method";
  localparam logic [15:0] DEF_GAP      = 16'd28;
  localparam logic [15:0] DEF_DIST     = 16'd1004;
  localparam int unsigned MIN_DIST     = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RAND_PHASES  = 3;
  localparam int unsigned RAND_BYTES   = 40;

  // Indexes past the register list; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  kre_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  kre_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  kinetics_record_extractor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Traffic state shared by the driver, the receiver and the sequence.
  kre_in_t      file_bytes[$];
  kre_out_t     extracted_words[$];
  byte unsigned record_buf[$];
  bit           in_taken      = 1'b0;
  bit           idle_on       = 1'b1;
  bit           long_hold_req = 1'b0;
  int unsigned  tx_gap_left   = 0;
  int unsigned  rx_stall_left = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  error_count   = 0;

  // Parser model state and its copy of the registers.
  parse_phase_e ph;
  logic [7:0]   mark_win [MARKER_LEN];
  int unsigned  win_fill;
  logic [15:0]  skip_left;
  logic [23:0]  word_acc;
  logic [1:0]   word_pos;
  logic [31:0]  points_left;
  logic         time_half;
  logic [31:0]  field_left;
  int unsigned  end_pos;
  logic         end_ok;
  logic [15:0]  gap_cfg;
  logic [15:0]  dist_cfg;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Return the model to the marker search with a cleared window.
  function automatic void restart_search();
    ph = PH_SEARCH;
    foreach (mark_win[i]) mark_win[i] = '0;
    win_fill  = 0;
    skip_left = '0;
    word_acc  = '0;
    word_pos  = '0;
    time_half = 1'b0;
  endfunction

  // Collect one little-endian word; returns 1 with the word on its 4th byte.
  function automatic bit collect_word(input logic [7:0] b, output logic [31:0] w);
    w = '0;
    if (word_pos == 2'd3) begin
      w        = {b, word_acc};
      word_acc = '0;
      word_pos = '0;
      return 1'b1;
    end
    word_acc[8*word_pos +: 8] = b;
    word_pos = word_pos + 2'd1;
    return 1'b0;
  endfunction

  // Advance the parser model by one file byte and queue any result it causes.
  function automatic void extract_byte(input kre_in_t w);
    kre_out_t    r;
    bit          emit;
    bit          done;
    bit          hit;
    logic [31:0] word;
    logic [15:0] skip_dist;
    int unsigned idx;
    r    = '0;
    emit = 1'b0;
    case (ph)
      PH_SEARCH: begin
        for (idx = 0; idx < MARKER_LEN - 1; idx++) mark_win[idx] = mark_win[idx+1];
        mark_win[MARKER_LEN-1] = w.data_byte;
        if (win_fill < MARKER_LEN) win_fill++;
        hit = 1'b1;
        for (idx = 0; idx < MARKER_LEN; idx++) begin
          if (mark_win[idx] != MARKER_S[idx]) hit = 1'b0;
        end
        if (hit && win_fill >= MARKER_LEN) begin
          restart_search();
          skip_left = gap_cfg;
          ph = (gap_cfg != 0) ? PH_GAP : PH_COUNT;
        end
      end
      PH_GAP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) ph = PH_COUNT;
      end
      PH_COUNT: begin
        done = collect_word(w.data_byte, word);
        if (done) begin
          // The distance counts the four count bytes themselves.
          skip_dist   = (dist_cfg < MIN_DIST) ? 16'(MIN_DIST) : dist_cfg;
          points_left = word;
          time_half   = 1'b0;
          r.kind      = KIND_RECORD_START;
          r.value     = word;
          emit        = 1'b1;
          skip_left   = skip_dist - 16'(MIN_DIST);
          if (skip_left != 0) ph = PH_PRESKIP;
          else ph = (points_left != 0) ? PH_POINTS : PH_FLEN;
        end
      end
      PH_PRESKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) ph = (points_left != 0) ? PH_POINTS : PH_FLEN;
      end
      PH_POINTS: begin
        done = collect_word(w.data_byte, word);
        if (done) begin
          r.value = word;
          emit    = 1'b1;
          if (!time_half) begin
            r.kind    = KIND_ABSORBANCE;
            time_half = 1'b1;
          end else begin
            r.kind    = KIND_TIME;
            time_half = 1'b0;
            if (points_left != 0) points_left--;
            if (points_left == 0) ph = PH_FLEN;
          end
        end
      end
      PH_FLEN: begin
        done = collect_word(w.data_byte, word);
        if (done) begin
          r.kind     = KIND_FIELD_LEN;
          r.value    = word;
          emit       = 1'b1;
          field_left = word;
          end_pos    = 0;
          end_ok     = 1'b1;
          if (word == 0) r.field_last = 1'b1;
          else ph = PH_FBYTES;
        end
      end
      PH_FBYTES: begin
        r.kind  = KIND_FIELD_BYTE;
        r.value = {24'd0, w.data_byte};
        emit    = 1'b1;
        if (end_pos < END_LEN) begin
          if (w.data_byte != END_S[end_pos]) end_ok = 1'b0;
          end_pos++;
        end
        if (field_left != 0) field_left--;
        if (field_left == 0) begin
          r.field_last = 1'b1;
          if (end_ok && end_pos >= END_LEN) begin
            r.record_last = 1'b1;
            restart_search();
          end else begin
            ph = PH_FLEN;
          end
        end
      end
      default: restart_search();
    endcase
    if (w.last_byte) restart_search();
    if (emit) extracted_words.push_back(r);
  endfunction

  // Report one result field that differs from the prediction.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endtask

  // Monitor: check result words, feed accepted bytes to the model, watchdog.
  always @(posedge clk_i) begin
    kre_out_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (extracted_words.size() == 0) begin
          $error("result word with none pending: kind %0d value 0x%08h",
                 out_data.kind, out_data.value);
          error_count++;
        end else begin
          want = extracted_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data.kind));
          check_field("value", want.value, out_data.value);
          check_field("field_last", 32'(want.field_last), 32'(out_data.field_last));
          check_field("record_last", 32'(want.record_last), 32'(out_data.record_last));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        extract_byte(in_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Byte driver: offers queued bytes with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (tx_gap_left != 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (idle_on && file_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
        tx_gap_left = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (file_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= file_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Write one register and update the model's copy once the word is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_GAP_TO_COUNT) gap_cfg = data;
    else if (idx == CFG_COUNT_TO_POINTS) dist_cfg = data;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every byte is taken and every result has come back.
  task automatic wait_idle();
    while (file_bytes.size() != 0 || in_valid || extracted_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_text(string s);
    int idx;
    for (idx = 0; idx < s.len(); idx++) record_buf.push_back(s[idx]);
  endtask

  task automatic add_word(logic [31:0] w);
    int idx;
    for (idx = 0; idx < 4; idx++) record_buf.push_back(w[8*idx +: 8]);
  endtask

  task automatic add_noise(int unsigned n);
    repeat (n) record_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_field_text(string s);
    add_word(32'(s.len()));
    add_text(s);
  endtask

  // Marker, gap and count, then the skip up to the point data.
  task automatic add_header(logic [31:0] count);
    add_text(MARKER_S);
    add_noise(gap_cfg);
    add_word(count);
    add_noise(((dist_cfg < MIN_DIST) ? MIN_DIST : dist_cfg) - MIN_DIST);
  endtask

  // A complete record with random points and fields and a closing field.
  task automatic add_record(int unsigned npoints, int unsigned nfields);
    int unsigned extra;
    add_header(npoints);
    repeat (2 * npoints) add_word($urandom());
    repeat (nfields) begin
      extra = $urandom_range(0, 6);
      add_word(extra);
      add_noise(extra);
    end
    extra = $urandom_range(0, 3);
    add_word(END_LEN + extra);
    add_text(END_S);
    add_noise(extra);
  endtask

  // Move the built bytes to the driver, optionally cut short, flagging the last.
  task automatic send_bytes(bit mark_last, bit cut);
    kre_in_t item;
    int      keep;
    int      idx;
    if (cut && record_buf.size() > 1) begin
      keep = $urandom_range(1, record_buf.size() - 1);
      record_buf = record_buf[0:keep-1];
    end
    for (idx = 0; idx < record_buf.size(); idx++) begin
      item.data_byte = record_buf[idx];
      item.last_byte = mark_last && (idx == record_buf.size() - 1);
      file_bytes.push_back(item);
    end
    record_buf.delete();
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned phase_no;
    int unsigned queued;
    int unsigned pick;
    gap_cfg  = DEF_GAP;
    dist_cfg = DEF_DIST;
    restart_search();
    points_left = '0;
    field_left  = '0;
    end_pos     = 0;
    end_ok      = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: a partial marker at file start, then a record start
    // whose point data is cut off by the last byte.
    add_text("Store");
    send_bytes(1'b1, 1'b0);
    add_text(MARKER_S);
    add_noise(gap_cfg);
    add_word(32'd3);
    add_noise(4);
    send_bytes(1'b1, 1'b0);
    wait_idle();

    // No gap and a distance below four: the closing field test.
    write_reg(CFG_GAP_TO_COUNT, 16'd0);
    write_reg(CFG_COUNT_TO_POINTS, 16'd0);
    // A marker that ends right after a closing field must not match.
    add_header(0);
    add_field_text({END_S, "TContinuumStor"});
    add_text("e");
    add_noise(8);
    send_bytes(1'b0, 1'b0);
    add_header(0);
    add_field_text("");
    add_field_text("End Meth");
    add_field_text("End Metho");
    add_field_text("End Methox");
    add_field_text(END_S);
    send_bytes(1'b0, 1'b0);
    // File ends on the marker's final byte.
    add_text(MARKER_S);
    send_bytes(1'b1, 1'b0);
    add_record(2, 1);
    send_bytes(1'b0, 1'b0);
    wait_idle();

    write_reg(CFG_COUNT_TO_POINTS, 16'd3);
    write_reg(CFG_GAP_TO_COUNT, 16'd1);
    add_record(2, 2);
    send_bytes(1'b0, 1'b0);
    wait_idle();

    // Truncated inside the count word, then a clean record.
    write_reg(CFG_COUNT_TO_POINTS, 16'd1);
    add_text(MARKER_S);
    add_noise(1);
    add_noise(2);
    send_bytes(1'b1, 1'b0);
    add_record(1, 0);
    send_bytes(1'b0, 1'b0);
    wait_idle();

    // Largest count and field length, both dropped by the last byte.
    write_reg(CFG_COUNT_TO_POINTS, 16'd4);
    write_reg(CFG_GAP_TO_COUNT, 16'd2);
    write_reg(CFG_UNUSED_A, 16'($urandom()));
    write_reg(CFG_UNUSED_B, 16'($urandom()));
    add_header(32'hFFFF_FFFF);
    repeat (6) add_word($urandom());
    add_noise(2);
    send_bytes(1'b1, 1'b0);
    add_header(0);
    add_word(32'hFFFF_FFFF);
    add_noise(5);
    send_bytes(1'b1, 1'b0);
    wait_idle();

    // Largest skip distances, each cut short by the last byte.
    write_reg(CFG_GAP_TO_COUNT, 16'hFFFF);
    write_reg(CFG_COUNT_TO_POINTS, 16'hFFFF);
    add_text(MARKER_S);
    add_noise(10);
    send_bytes(1'b1, 1'b0);
    wait_idle();
    write_reg(CFG_GAP_TO_COUNT, 16'd2);
    add_text(MARKER_S);
    add_noise(2);
    add_word(32'd1);
    add_noise(10);
    send_bytes(1'b1, 1'b0);

    // Random phases; the last one runs without idling.
    for (phase_no = 0; phase_no < RAND_PHASES; phase_no++) begin
      wait_idle();
      if (phase_no == RAND_PHASES - 1) idle_on = 1'b0;
      write_reg(CFG_GAP_TO_COUNT, 16'($urandom_range(0, 6)));
      write_reg(CFG_COUNT_TO_POINTS, 16'($urandom_range(0, 10)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_A, 16'($urandom()));
      queued = 0;
      while (queued < RAND_BYTES) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          add_record($urandom_range(0, 4), $urandom_range(0, 3));
          queued += record_buf.size();
          send_bytes(1'b1, 1'b1);
        end else if (pick == 1) begin
          add_noise($urandom_range(1, 20));
          queued += record_buf.size();
          send_bytes(1'($urandom_range(0, 1)), 1'b0);
        end else if (pick == 2) begin
          // A marker with its final byte in the wrong case.
          add_text("TContinuumStorE");
          add_noise($urandom_range(0, 8));
          queued += record_buf.size();
          send_bytes(1'b0, 1'b0);
        end else begin
          add_noise($urandom_range(0, 5));
          add_record($urandom_range(0, 4), $urandom_range(0, 3));
          queued += record_buf.size();
          send_bytes(1'b0, 1'b0);
        end
      end
      // Hold results back while bytes keep coming so the input stalls.
      if (phase_no == 1) long_hold_req = 1'b1;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kre_pkg.sv
rtl/kre_marker_window.sv
rtl/kre_parser.sv
rtl/kre_out_reg.sv
rtl/kinetics_record_extractor_core.sv
test/kinetics_record_extractor_core_tb.sv
